// File: rtl/rsd_pkg.sv
// Package of shared types, constants and key functions for the radix sorter.
`timescale 1ns / 1ps
package rsd_pkg;

   localparam int MAX_ITEMS  = 1024;
   localparam int DIGIT_BITS = 8;
   localparam int KEY_W      = 64;
   localparam int RADIX      = 1 << DIGIT_BITS;
   localparam int PASSES     = (KEY_W + DIGIT_BITS - 1) / DIGIT_BITS;
   localparam int IDX_W      = $clog2(MAX_ITEMS);
   localparam int CNT_W      = IDX_W + 1;
   localparam int PASS_W     = (PASSES > 1) ? $clog2(PASSES) : 1;

   localparam logic [KEY_W-1:0] SIGN_BIT = {1'b1, {(KEY_W-1){1'b0}}};
   localparam logic [KEY_W-1:0] MAG_MASK = {1'b0, {(KEY_W-1){1'b1}}};

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_FETCH = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic             req_type;
      logic [KEY_W-1:0] value_bits;
      logic             last_value;
   } sort_req_type;

   typedef struct packed {
      logic [KEY_W-1:0] sorted_bits;
      logic             last_sorted;
      logic [1:0]       status;
   } sort_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FETCH,
      ST_CLEAR,
      ST_CNT_RD,
      ST_CNT_LOOK,
      ST_CNT_WR,
      ST_SUM_RD,
      ST_SUM_WR,
      ST_SC_RD,
      ST_SC_LOOK,
      ST_SC_WR
   } state_type;

   function automatic logic [KEY_W-1:0] to_key(input logic [KEY_W-1:0] bits);
      return ((bits & SIGN_BIT) != '0) ? ~bits : (bits | SIGN_BIT);
   endfunction

   function automatic logic [KEY_W-1:0] from_key(input logic [KEY_W-1:0] key);
      return ((key & SIGN_BIT) != '0) ? (key & MAG_MASK) : ~key;
   endfunction

   function automatic logic [DIGIT_BITS-1:0] digit_of(input logic [KEY_W-1:0] key,
                                                      input logic [PASS_W-1:0] pass);
      logic [KEY_W-1:0] shifted;
      shifted = key >> (int'(pass) * DIGIT_BITS);
      return shifted[DIGIT_BITS-1:0];
   endfunction

endpackage

// File: rtl/rsd_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module rsd_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/radix_sort_doubles_lsd.sv
// Top level of the LSD radix sorter for IEEE-754 double bit patterns.
//
//   Channel   Direction   Handshake            Carries
//   req_      in          req_valid/req_stall  load or fetch request
//   rsp_      out         rsp_valid/rsp_stall  sorted value or error status
//
// A load is taken in the idle state; a successful fetch reads the store, then the
// fetch state registers the result. Error responses (fetch with nothing left, load
// into a full store) are registered straight from the idle state. A last load
// starts eight passes, each clearing the count table, counting the items, forming
// running sums and scattering the items; the request side is stalled throughout.
// Reset is synchronous and clears all control state; store contents stay undefined.
// A request is taken in the idle state while the result register is empty or being
// emptied.
`timescale 1ns / 1ps
module radix_sort_doubles_lsd
   import rsd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  sort_req_type req_payload,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output sort_rsp_type rsp_payload
);

   // Control registers.
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  item_count_ff, item_count_in;
   logic [CNT_W-1:0]  read_pointer_ff, read_pointer_in;
   logic              sorted_ready_ff, sorted_ready_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [DIGIT_BITS-1:0] digit_ff, digit_in;
   logic [PASS_W-1:0] pass_ff, pass_in;
   // The store that holds the current keys; the other receives each scatter.
   logic              src_ff, src_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Data registers.
   logic [KEY_W-1:0]      key_ff, key_in;
   logic [DIGIT_BITS-1:0] dsel_ff, dsel_in;
   logic [CNT_W-1:0]      sum_ff, sum_in;
   sort_rsp_type          rsp_ff, rsp_in;

   // Memory ports.
   logic             st_wr_en [2];
   logic [IDX_W-1:0] st_wr_addr;
   logic [KEY_W-1:0] st_wr_data;
   logic [IDX_W-1:0] st_rd_addr;
   logic [KEY_W-1:0] st_rd_data [2];
   logic [KEY_W-1:0] src_data;

   logic                  cnt_wr_en;
   logic [DIGIT_BITS-1:0] cnt_wr_addr;
   logic [CNT_W-1:0]      cnt_wr_data;
   logic [DIGIT_BITS-1:0] cnt_rd_addr;
   logic [CNT_W-1:0]      cnt_rd_data;

   logic             accept;
   logic             out_free;
   logic [CNT_W-1:0] eff_count;
   logic [CNT_W-1:0] sum_next;
   logic [CNT_W-1:0] slot;
   logic             wr_src;
   logic             wr_dst;

   rsd_ram #(.WIDTH(KEY_W), .DEPTH(MAX_ITEMS)) u_store0 (
      .clock  (clock),
      .wr_en  (st_wr_en[0]),
      .wr_addr(st_wr_addr),
      .wr_data(st_wr_data),
      .rd_addr(st_rd_addr),
      .rd_data(st_rd_data[0])
   );

   rsd_ram #(.WIDTH(KEY_W), .DEPTH(MAX_ITEMS)) u_store1 (
      .clock  (clock),
      .wr_en  (st_wr_en[1]),
      .wr_addr(st_wr_addr),
      .wr_data(st_wr_data),
      .rd_addr(st_rd_addr),
      .rd_data(st_rd_data[1])
   );

   rsd_ram #(.WIDTH(CNT_W), .DEPTH(RADIX)) u_counts (
      .clock  (clock),
      .wr_en  (cnt_wr_en),
      .wr_addr(cnt_wr_addr),
      .wr_data(cnt_wr_data),
      .rd_addr(cnt_rd_addr),
      .rd_data(cnt_rd_data)
   );

   // The result register may take a new result when it is empty or draining now.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;

   assign src_data  = src_ff ? st_rd_data[1] : st_rd_data[0];
   assign eff_count = sorted_ready_ff ? '0 : item_count_ff;
   assign sum_next  = sum_ff + cnt_rd_data;
   assign slot      = cnt_rd_data - CNT_W'(1);

   // Loads write into the source store, scatters into the other one.
   assign st_wr_en[0] = (wr_src && !src_ff) || (wr_dst && src_ff);
   assign st_wr_en[1] = (wr_src && src_ff) || (wr_dst && !src_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         item_count_ff   <= '0;
         read_pointer_ff <= '0;
         sorted_ready_ff <= 1'b0;
         idx_ff          <= '0;
         digit_ff        <= '0;
         pass_ff         <= '0;
         src_ff          <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         item_count_ff   <= item_count_in;
         read_pointer_ff <= read_pointer_in;
         sorted_ready_ff <= sorted_ready_in;
         idx_ff          <= idx_in;
         digit_ff        <= digit_in;
         pass_ff         <= pass_in;
         src_ff          <= src_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff  <= key_in;
      dsel_ff <= dsel_in;
      sum_ff  <= sum_in;
      rsp_ff  <= rsp_in;
   end

   always_comb begin
      state_in        = state_ff;
      item_count_in   = item_count_ff;
      read_pointer_in = read_pointer_ff;
      sorted_ready_in = sorted_ready_ff;
      idx_in          = idx_ff;
      digit_in        = digit_ff;
      pass_in         = pass_ff;
      src_in          = src_ff;
      key_in          = key_ff;
      dsel_in         = dsel_ff;
      sum_in          = sum_ff;
      rsp_in          = rsp_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;

      wr_src      = 1'b0;
      wr_dst      = 1'b0;
      st_wr_addr  = eff_count[IDX_W-1:0];
      st_wr_data  = to_key(req_payload.value_bits);
      st_rd_addr  = idx_ff[IDX_W-1:0];
      cnt_wr_en   = 1'b0;
      cnt_wr_addr = digit_ff;
      cnt_wr_data = '0;
      cnt_rd_addr = digit_ff;

      unique case (state_ff)
         ST_IDLE: begin
            st_rd_addr = read_pointer_ff[IDX_W-1:0];
            if (accept) begin
               if (req_payload.req_type == REQ_LOAD) begin
                  // A load after a finished sort opens a new batch.
                  if (sorted_ready_ff) begin
                     sorted_ready_in = 1'b0;
                     read_pointer_in = '0;
                  end
                  if (eff_count < CNT_W'(MAX_ITEMS)) begin
                     wr_src        = 1'b1;
                     item_count_in = eff_count + CNT_W'(1);
                  end else begin
                     item_count_in = eff_count;
                     rsp_valid_in  = 1'b1;
                     rsp_in        = '{sorted_bits: '0, last_sorted: 1'b0,
                                       status: STATUS_FULL};
                  end
                  if (req_payload.last_value) begin
                     pass_in  = '0;
                     digit_in = '0;
                     state_in = ST_CLEAR;
                  end
               end else if (sorted_ready_ff && (read_pointer_ff < item_count_ff)) begin
                  state_in = ST_FETCH;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{sorted_bits: '0, last_sorted: 1'b0,
                                   status: STATUS_EMPTY};
               end
            end
         end

         ST_FETCH: begin
            rsp_valid_in    = 1'b1;
            rsp_in          = '{sorted_bits: from_key(src_data),
                                last_sorted: (read_pointer_ff + CNT_W'(1)) == item_count_ff,
                                status: STATUS_OK};
            read_pointer_in = read_pointer_ff + CNT_W'(1);
            state_in        = ST_IDLE;
         end

         ST_CLEAR: begin
            cnt_wr_en = 1'b1;
            digit_in  = digit_ff + DIGIT_BITS'(1);
            if (digit_ff == DIGIT_BITS'(RADIX - 1)) begin
               idx_in   = '0;
               state_in = ST_CNT_RD;
            end
         end

         ST_CNT_RD: begin
            state_in = ST_CNT_LOOK;
         end

         ST_CNT_LOOK: begin
            dsel_in     = digit_of(src_data, pass_ff);
            cnt_rd_addr = dsel_in;
            state_in    = ST_CNT_WR;
         end

         ST_CNT_WR: begin
            cnt_wr_en   = 1'b1;
            cnt_wr_addr = dsel_ff;
            cnt_wr_data = cnt_rd_data + CNT_W'(1);
            idx_in      = idx_ff + CNT_W'(1);
            if ((idx_ff + CNT_W'(1)) == item_count_ff) begin
               digit_in = '0;
               sum_in   = '0;
               state_in = ST_SUM_RD;
            end else begin
               state_in = ST_CNT_RD;
            end
         end

         ST_SUM_RD: begin
            state_in = ST_SUM_WR;
         end

         ST_SUM_WR: begin
            // Each entry becomes the end of its digit's bucket.
            cnt_wr_en   = 1'b1;
            cnt_wr_data = sum_next;
            sum_in      = sum_next;
            digit_in    = digit_ff + DIGIT_BITS'(1);
            if (digit_ff == DIGIT_BITS'(RADIX - 1)) begin
               idx_in   = item_count_ff - CNT_W'(1);
               state_in = ST_SC_RD;
            end else begin
               state_in = ST_SUM_RD;
            end
         end

         ST_SC_RD: begin
            state_in = ST_SC_LOOK;
         end

         ST_SC_LOOK: begin
            key_in      = src_data;
            dsel_in     = digit_of(src_data, pass_ff);
            cnt_rd_addr = dsel_in;
            state_in    = ST_SC_WR;
         end

         ST_SC_WR: begin
            // Scattering from the last item down keeps each bucket stable.
            cnt_wr_en   = 1'b1;
            cnt_wr_addr = dsel_ff;
            cnt_wr_data = slot;
            wr_dst      = 1'b1;
            st_wr_addr  = slot[IDX_W-1:0];
            st_wr_data  = key_ff;
            if (idx_ff == '0) begin
               src_in = !src_ff;
               if (pass_ff == PASS_W'(PASSES - 1)) begin
                  sorted_ready_in = 1'b1;
                  read_pointer_in = '0;
                  state_in        = ST_IDLE;
               end else begin
                  pass_in  = pass_ff + PASS_W'(1);
                  digit_in = '0;
                  state_in = ST_CLEAR;
               end
            end else begin
               idx_in   = idx_ff - CNT_W'(1);
               state_in = ST_SC_RD;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// File: rtl/rsd_checker.sv
// Port-level checker for the radix sorter, bound to the top level.
`timescale 1ns / 1ps
module rsd_checker
   import rsd_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input sort_req_type req_payload,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input sort_rsp_type rsp_payload
);

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_payload))
      else $error("stalled request changed");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.status == STATUS_OK ||
                     rsp_payload.status == STATUS_EMPTY ||
                     rsp_payload.status == STATUS_FULL))
      else $error("undefined status code");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != STATUS_OK |->
         rsp_payload.sorted_bits == '0 && !rsp_payload.last_sorted)
      else $error("error response carries data");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid straight after reset");

endmodule

bind radix_sort_doubles_lsd rsd_checker u_rsd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .req_payload(req_payload),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_payload(rsp_payload)
);

// File: tb/sv/tb_radix_sort_doubles_lsd.sv
// Self-checking testbench for the LSD radix sorter of double bit patterns.
`timescale 1ns / 1ps
module tb_radix_sort_doubles_lsd
   import rsd_pkg::*;
();

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   sort_req_type req_payload;
   logic         rsp_valid;
   logic         rsp_stall;
   sort_rsp_type rsp_payload;

   radix_sort_doubles_lsd uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload)
   );

   // Requests waiting to be driven, and the responses the predictor expects.
   sort_req_type pending_reqs[$];
   sort_rsp_type expected_rsps[$];

   // The predictor's own view of the batch: the loaded values, and the sorted
   // list that fetches walk through once a last load has been seen.
   logic [63:0] batch_vals[$];
   logic [63:0] sorted_vals[$];
   int unsigned fetch_pos;
   bit          batch_sorted;

   int unsigned error_count;
   int unsigned cycle_count;
   int unsigned loads_sent;
   int unsigned fetches_sent;
   int unsigned full_drops;
   int unsigned rsp_count;
   bit          stim_done;
   bit          calm;

   localparam int unsigned CYCLE_LIMIT = 10_000_000;

   // Order-preserving unsigned key of a double bit pattern.
   function automatic logic [63:0] order_key(logic [63:0] v);
      return v[63] ? ~v : {1'b1, v[62:0]};
   endfunction

   // Sorts the current batch by key. Equal keys are equal patterns, so
   // stability cannot be seen and a plain insertion sort is enough.
   task automatic sort_batch();
      logic [63:0] tmp;
      int j;
      sorted_vals = batch_vals;
      for (int i = 1; i < sorted_vals.size(); i++) begin
         tmp = sorted_vals[i];
         j = i - 1;
         while (j >= 0 && order_key(sorted_vals[j]) > order_key(tmp)) begin
            sorted_vals[j+1] = sorted_vals[j];
            j--;
         end
         sorted_vals[j+1] = tmp;
      end
      fetch_pos = 0;
      batch_sorted = 1'b1;
   endtask

   // Works out the response, if any, for one accepted request.
   task automatic predict_request(sort_req_type r);
      sort_rsp_type e;
      if (r.req_type == REQ_LOAD) begin
         if (batch_sorted) begin
            batch_sorted = 1'b0;
            batch_vals.delete();
            fetch_pos = 0;
         end
         if (batch_vals.size() < MAX_ITEMS) begin
            batch_vals.push_back(r.value_bits);
         end else begin
            e.sorted_bits = '0;
            e.last_sorted = 1'b0;
            e.status      = STATUS_FULL;
            expected_rsps.push_back(e);
         end
         if (r.last_value) sort_batch();
      end else begin
         if (batch_sorted && fetch_pos < sorted_vals.size()) begin
            e.sorted_bits = sorted_vals[fetch_pos];
            e.last_sorted = (fetch_pos + 1 == sorted_vals.size());
            e.status      = STATUS_OK;
            fetch_pos++;
         end else begin
            e.sorted_bits = '0;
            e.last_sorted = 1'b0;
            e.status      = STATUS_EMPTY;
         end
         expected_rsps.push_back(e);
      end
   endtask

   task automatic report_mismatch(string what);
      $display("MISMATCH at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   function automatic sort_req_type make_load(logic [63:0] v, bit is_last);
      sort_req_type r;
      r.req_type   = REQ_LOAD;
      r.value_bits = v;
      r.last_value = is_last;
      return r;
   endfunction

   function automatic sort_req_type make_fetch();
      sort_req_type r;
      r.req_type   = REQ_FETCH;
      r.value_bits = {$urandom, $urandom};
      r.last_value = $urandom_range(0, 1);
      return r;
   endfunction

   // A random double pattern, biased towards the awkward ones: zeros of both
   // signs, infinities, NaNs, denormals and near-duplicates.
   function automatic logic [63:0] random_double();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 9))
         0: v = {v[63], 63'd0};
         1: v = {v[63], 11'h7FF, 52'd0};
         2: v = {v[63], 11'h7FF, v[51:0] | 52'd1};
         3: v = {v[63], 11'h000, v[51:0]};
         4: v = {v[63], 11'h3FF, 44'd0, v[7:0]};
         5: v = {v[63], 55'd0, v[7:0]};
         default: ;
      endcase
      return v;
   endfunction

   // Queues one batch of loads, the last one marked, then some fetches.
   task automatic queue_batch(int unsigned n, int unsigned extra);
      for (int unsigned i = 0; i < n; i++)
         pending_reqs.push_back(make_load(random_double(), i == n - 1));
      for (int unsigned i = 0; i < extra; i++)
         pending_reqs.push_back(make_fetch());
   endtask

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Stimulus: directed cases first, then random batches.
   initial begin
      int unsigned n;
      reset = 1'b1;
      stim_done = 1'b0;
      // Fetch before any sort gives the empty status.
      pending_reqs.push_back(make_fetch());
      // Extremes of the field: zeros, ones, the sign bit alone and its complement.
      pending_reqs.push_back(make_load(64'd0, 1'b0));
      pending_reqs.push_back(make_load(64'hFFFF_FFFF_FFFF_FFFF, 1'b0));
      pending_reqs.push_back(make_load(SIGN_BIT, 1'b0));
      pending_reqs.push_back(make_load(MAG_MASK, 1'b0));
      pending_reqs.push_back(make_load(64'h3FF0_0000_0000_0000, 1'b0));
      pending_reqs.push_back(make_load(64'hBFF0_0000_0000_0000, 1'b0));
      pending_reqs.push_back(make_load(64'h3FF0_0000_0000_0000, 1'b1));
      // Drain the batch and go one past its end.
      for (int i = 0; i < 8; i++) pending_reqs.push_back(make_fetch());
      // A batch of a single value.
      pending_reqs.push_back(make_load(64'h7FF0_0000_0000_0000, 1'b1));
      pending_reqs.push_back(make_fetch());
      pending_reqs.push_back(make_fetch());
      // A new batch started part way through fetching an old one.
      pending_reqs.push_back(make_load(64'h8000_0000_0000_0001, 1'b0));
      pending_reqs.push_back(make_load(64'h0000_0000_0000_0001, 1'b1));
      pending_reqs.push_back(make_fetch());
      pending_reqs.push_back(make_load(64'hC000_0000_0000_0000, 1'b1));
      pending_reqs.push_back(make_fetch());
      pending_reqs.push_back(make_fetch());
      // Random batches of mostly small sizes, with stray fetches as noise.
      while (pending_reqs.size() < 420) begin
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 16);
         queue_batch(n, n + $urandom_range(0, 2) - ($urandom_range(0, 3) == 0 ? n / 2 : 0));
         if ($urandom_range(0, 7) == 0) pending_reqs.push_back(make_fetch());
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      stim_done = 1'b1;
   end

   // Long calm stretch with no idling on either side, in the middle of the run.
   always_comb calm = (cycle_count > 30_000) && (cycle_count < 45_000);

   // Request driver: one nonblocking update of each signal per edge.
   always @(posedge clock) begin
      sort_req_type cur;
      if (reset || !stim_done) begin
         req_valid   <= 1'b0;
         req_payload <= '0;
      end else begin
         if (req_valid && !req_stall) begin
            cur = pending_reqs.pop_front();
            predict_request(cur);
            if (cur.req_type == REQ_LOAD) loads_sent++;
            else fetches_sent++;
         end
         if (!(req_valid && req_stall)) begin
            if (pending_reqs.size() != 0 && (calm || $urandom_range(0, 99) >= 19)) begin
               req_valid   <= 1'b1;
               req_payload <= pending_reqs[0];
            end else begin
               req_valid   <= 1'b0;
            end
         end
      end
   end

   // Response monitor and stall generator.
   always @(posedge clock) begin
      sort_rsp_type exp_rsp;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsp_count++;
            if (expected_rsps.size() == 0) begin
               report_mismatch($sformatf("unexpected response %h", rsp_payload));
            end else begin
               exp_rsp = expected_rsps.pop_front();
               if (rsp_payload.sorted_bits !== exp_rsp.sorted_bits)
                  report_mismatch($sformatf("sorted_bits %h, expected %h",
                                            rsp_payload.sorted_bits, exp_rsp.sorted_bits));
               if (rsp_payload.last_sorted !== exp_rsp.last_sorted)
                  report_mismatch($sformatf("last_sorted %b, expected %b",
                                            rsp_payload.last_sorted, exp_rsp.last_sorted));
               if (rsp_payload.status !== exp_rsp.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_payload.status, exp_rsp.status));
               if (exp_rsp.status == STATUS_FULL) full_drops++;
            end
         end
         rsp_stall <= !calm && ($urandom_range(0, 99) < 19);
      end
   end

   // Cycle counter, end of run and timeout.
   initial begin
      error_count = 0;
      cycle_count = 0;
      loads_sent = 0;
      fetches_sent = 0;
      full_drops = 0;
      rsp_count = 0;
      req_valid = 1'b0;
      req_payload = '0;
      rsp_stall = 1'b0;
      fetch_pos = 0;
      batch_sorted = 1'b0;
      while (!(stim_done && pending_reqs.size() == 0 && !req_valid
               && expected_rsps.size() == 0) && cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout with %0d responses outstanding", expected_rsps.size());
         $display("simulation failed");
         $finish;
      end else begin
         // Let any late spurious response show up before judging.
         repeat (50) @(posedge clock);
         if (expected_rsps.size() != 0)
            report_mismatch("responses left outstanding");
         $display("Covered %0d loads and %0d fetches, %0d responses, %0d dropped loads.",
                  loads_sent, fetches_sent, rsp_count, full_drops);
         if (error_count == 0) begin
            $display("simulation ok");
         end else begin
            $display("simulation failed");
         end
         $finish;
      end
   end

endmodule
